FILE: src/cbm_pkg.sv
// Shared widths, defaults and blend mode codes for the coverage blend unit.
// No dependencies; every other file imports this package.
`default_nettype none

package cbm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 18;
    localparam int OUT_W         = 17;
    localparam int MODE_W        = 4;

    localparam logic [MODE_W-1:0] MODE_MULTIPLY  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_OVERLAY   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BURN      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_HARDMIX   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_LINBURN   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DODGE     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DARKEN    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SUBTRACT  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_HEIGHT    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_LINHEIGHT = 4'd9;

endpackage

`default_nettype wire

FILE: src/cbm_channels.sv
// Valid/ready channel interfaces for the coverage blend unit.
// Depends on cbm_pkg for the payload widths.
`default_nettype none

interface cbm_in_if;
    import cbm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] base_coverage;
    logic signed [IN_W-1:0] second_coverage;

    modport source (output valid, output base_coverage, output second_coverage, input ready);
    modport sink   (input valid, input base_coverage, input second_coverage, output ready);
endinterface

interface cbm_out_if;
    import cbm_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] blended_coverage;

    modport source (output valid, output blended_coverage, input ready);
    modport sink   (input valid, input blended_coverage, output ready);
endinterface

`default_nettype wire

FILE: src/cbm_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS+1 stages,
// elastic valid/ready flow with a pass-through tag. Depends on cbm_pkg.
`default_nettype none

module cbm_div_pipe #(
    parameter int FRAC_BITS = cbm_pkg::FRAC_BITS_DEF,
    parameter int TAG_W     = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FRAC_BITS:0]   in_rem,
    input  wire logic [FRAC_BITS:0]   in_div,
    input  wire logic [TAG_W-1:0]     in_tag,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [FRAC_BITS:0]        out_quo,
    output logic [TAG_W-1:0]          out_tag
);
    import cbm_pkg::*;

    localparam int W     = FRAC_BITS + 1;
    localparam int STEPS = W;

    logic [STEPS-1:0] valid_reg;
    logic [W-1:0]     rem_reg  [STEPS];
    logic [W-1:0]     div_reg  [STEPS];
    logic [W-1:0]     quo_reg  [STEPS];
    logic [TAG_W-1:0] tag_reg  [STEPS];

    logic [W-1:0]     rem_next [STEPS];
    logic [W-1:0]     quo_next [STEPS];
    logic [STEPS:0]   adv;

    assign adv[STEPS] = out_ready;
    assign in_ready   = adv[0];
    assign out_valid  = valid_reg[STEPS-1];
    assign out_quo    = quo_reg[STEPS-1];
    assign out_tag    = tag_reg[STEPS-1];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [W:0]       shifted;
        logic [W:0]       div_ext;
        logic             ge;
        logic             src_valid;
        logic [W-1:0]     src_div;
        logic [W-1:0]     src_quo;
        logic [TAG_W-1:0] src_tag;

        // first stage takes the remainder as is, later ones double it
        if (j == 0) begin : g_first
            assign shifted   = {1'b0, in_rem};
            assign src_valid = in_valid;
            assign src_div   = in_div;
            assign src_quo   = '0;
            assign src_tag   = in_tag;
        end
        else begin : g_rest
            assign shifted   = {rem_reg[j-1], 1'b0};
            assign src_valid = valid_reg[j-1];
            assign src_div   = div_reg[j-1];
            assign src_quo   = quo_reg[j-1];
            assign src_tag   = tag_reg[j-1];
        end

        assign div_ext = {1'b0, src_div};
        assign ge      = (shifted >= div_ext);

        always_comb
        begin
            logic [W:0] diff;
            diff        = shifted - div_ext;
            rem_next[j] = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next[j] = {src_quo[W-2:0], ge};
        end

        assign adv[j] = !valid_reg[j] || adv[j+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (adv[j])
            begin
                valid_reg[j] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[j])
            begin
                rem_reg[j] <= rem_next[j];
                div_reg[j] <= src_div;
                quo_reg[j] <= quo_next[j];
                tag_reg[j] <= src_tag;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/coverage_blend_modes_unit.sv
// Path: clamp, multiply, fixed-result stages, the divider, then the output register.
// Throughput: one beat per cycle; every stage is elastic, so a stalled output
//   only holds the stages behind it that are full.
// Every beat passes through the divider, which burn and dodge use, one quotient bit a stage.
// Reset clears all valid bits and sets the blend mode to multiply.
`default_nettype none

module coverage_blend_modes_unit #(
    parameter int FRAC_BITS = cbm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [cbm_pkg::MODE_W-1:0]  cfg_data,
    cbm_in_if.sink                           cov_in,
    cbm_out_if.source                        cov_out
);
    import cbm_pkg::*;

    localparam int W  = FRAC_BITS + 1;
    localparam int CW = (W > OUT_W) ? W : OUT_W;
    localparam int PW = 2 * W;
    localparam logic [W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W-1:0] HALF = ONE >> 1;

    typedef struct packed {
        logic [W-1:0] fixed_res;
        logic         use_div;
        logic         burn;
        logic         sat;
    } div_tag_t;

    localparam int TAG_W = $bits(div_tag_t);

    function automatic logic [W-1:0] clamp_cov(input logic [IN_W-1:0] raw);
        logic [CW-1:0] mag;
        logic [CW-1:0] one_ext;
        mag     = CW'(raw[IN_W-2:0]);
        one_ext = CW'(ONE);
        if (raw[IN_W-1])
            return '0;
        else if (mag > one_ext)
            return ONE;
        else
            return mag[W-1:0];
    endfunction

    logic [MODE_W-1:0] blend_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= MODE_MULTIPLY;
        end
        else if (cfg_we)
        begin
            blend_mode_reg <= cfg_data;
        end
    end

    // ---------------- stage 0: clamp ----------------
    logic              s0_valid_reg;
    logic [W-1:0]      s0_a_reg;
    logic [W-1:0]      s0_b_reg;
    logic [MODE_W-1:0] s0_mode_reg;
    logic              s0_adv;

    // ---------------- stage 1: multiply, divide operands ----------------
    logic              s1_valid_reg;
    logic [W-1:0]      s1_a_reg;
    logic [W-1:0]      s1_b_reg;
    logic [MODE_W-1:0] s1_mode_reg;
    logic              s1_ov_hi_reg;
    logic [PW-1:0]     s1_prod_reg;
    logic [W-1:0]      s1_x_reg;
    logic [W-1:0]      s1_d_reg;
    logic              s1_adv;
    logic              s1_ov_hi_next;
    logic [W-1:0]      mul_x;
    logic [W-1:0]      mul_y;
    logic [PW-1:0]     s1_prod_next;
    logic [W-1:0]      s1_x_next;
    logic [W-1:0]      s1_d_next;

    // ---------------- stage 2: fixed results, pole and range checks ----------------
    logic              s2_valid_reg;
    div_tag_t          s2_tag_reg;
    logic [W-1:0]      s2_x_reg;
    logic [W-1:0]      s2_d_reg;
    logic              s2_adv;
    div_tag_t          s2_tag_next;

    // ---------------- divider and output ----------------
    logic              div_ready;
    logic              div_valid;
    logic [W-1:0]      div_quo;
    logic [TAG_W-1:0]  div_tag_bits;
    div_tag_t          div_tag;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;
    logic              out_adv;

    assign out_adv = !out_valid_reg || cov_out.ready;
    assign s2_adv  = !s2_valid_reg || div_ready;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign s0_adv  = !s0_valid_reg || s1_adv;

    assign cov_in.ready             = s0_adv;
    assign cov_out.valid            = out_valid_reg;
    assign cov_out.blended_coverage = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_adv)
                s0_valid_reg <= cov_in.valid;
            if (s1_adv)
                s1_valid_reg <= s0_valid_reg;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= div_valid;
        end
    end

    // overlay upper half multiplies the complements
    always_comb
    begin
        s1_ov_hi_next = (s0_mode_reg == MODE_OVERLAY) && (s0_a_reg >= HALF);
        mul_x         = s1_ov_hi_next ? ONE - s0_a_reg : s0_a_reg;
        mul_y         = s1_ov_hi_next ? ONE - s0_b_reg : s0_b_reg;
        s1_prod_next  = PW'(mul_x) * PW'(mul_y);
        if (s0_mode_reg == MODE_DODGE)
        begin
            s1_x_next = s0_a_reg;
            s1_d_next = ONE - s0_b_reg;
        end
        else
        begin
            s1_x_next = ONE - s0_a_reg;
            s1_d_next = s0_b_reg;
        end
    end

    always_comb
    begin
        logic [PW-1:0] half_q;
        logic [PW-1:0] full_q;
        logic [W:0]    sum;
        logic [W:0]    sum_sub;
        full_q  = s1_prod_reg >> FRAC_BITS;
        half_q  = s1_prod_reg >> (FRAC_BITS - 1);
        sum     = {1'b0, s1_a_reg} + {1'b0, s1_b_reg};
        sum_sub = sum - {1'b0, ONE};

        s2_tag_next.use_div = 1'b0;
        s2_tag_next.burn    = (s1_mode_reg == MODE_BURN);
        // quotient would not fit in FRAC_BITS+1 bits
        s2_tag_next.sat     = ({1'b0, s1_x_reg} >= {s1_d_reg, 1'b0});

        case (s1_mode_reg)
            MODE_MULTIPLY:
                s2_tag_next.fixed_res = full_q[W-1:0];
            MODE_OVERLAY:
                if (!s1_ov_hi_reg)
                    s2_tag_next.fixed_res = half_q[W-1:0];
                else if (half_q >= PW'(ONE))
                    s2_tag_next.fixed_res = '0;
                else
                    s2_tag_next.fixed_res = ONE - half_q[W-1:0];
            MODE_BURN:
            begin
                if (s1_a_reg >= ONE)
                    s2_tag_next.fixed_res = ONE;
                else
                begin
                    s2_tag_next.fixed_res = '0;
                    s2_tag_next.use_div   = (s1_b_reg != '0);
                end
            end
            MODE_HARDMIX:
                s2_tag_next.fixed_res = (sum >= {1'b0, ONE}) ? ONE : '0;
            MODE_LINBURN:
                s2_tag_next.fixed_res = (sum > {1'b0, ONE}) ? sum_sub[W-1:0] : '0;
            MODE_DODGE:
            begin
                if (s1_b_reg >= ONE)
                    s2_tag_next.fixed_res = ONE;
                else
                begin
                    s2_tag_next.fixed_res = '0;
                    s2_tag_next.use_div   = 1'b1;
                end
            end
            MODE_DARKEN:
                s2_tag_next.fixed_res = (s1_a_reg < s1_b_reg) ? s1_a_reg : s1_b_reg;
            MODE_SUBTRACT, MODE_HEIGHT:
                s2_tag_next.fixed_res = (s1_a_reg > s1_b_reg) ? s1_a_reg - s1_b_reg : '0;
            default:
                s2_tag_next.fixed_res = s1_a_reg;
        endcase

        // zero primary gives zero in every mode
        if (s1_a_reg == '0)
        begin
            s2_tag_next.fixed_res = '0;
            s2_tag_next.use_div   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv)
        begin
            s0_a_reg    <= clamp_cov(cov_in.base_coverage);
            s0_b_reg    <= clamp_cov(cov_in.second_coverage);
            s0_mode_reg <= blend_mode_reg;
        end
        if (s1_adv)
        begin
            s1_a_reg     <= s0_a_reg;
            s1_b_reg     <= s0_b_reg;
            s1_mode_reg  <= s0_mode_reg;
            s1_ov_hi_reg <= s1_ov_hi_next;
            s1_prod_reg  <= s1_prod_next;
            s1_x_reg     <= s1_x_next;
            s1_d_reg     <= s1_d_next;
        end
        if (s2_adv)
        begin
            s2_tag_reg <= s2_tag_next;
            s2_x_reg   <= s1_x_reg;
            s2_d_reg   <= s1_d_reg;
        end
        if (out_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    cbm_div_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_ready  (div_ready),
        .in_rem    (s2_x_reg),
        .in_div    (s2_d_reg),
        .in_tag    (s2_tag_reg),
        .out_valid (div_valid),
        .out_ready (out_adv),
        .out_quo   (div_quo),
        .out_tag   (div_tag_bits)
    );

    assign div_tag = div_tag_t'(div_tag_bits);

    always_comb
    begin
        logic [W-1:0]  q_clip;
        logic [W-1:0]  res;
        logic [CW-1:0] res_ext;
        q_clip = (div_tag.sat || div_quo > ONE) ? ONE : div_quo;
        if (div_tag.use_div)
            res = div_tag.burn ? ONE - q_clip : q_clip;
        else
            res = div_tag.fixed_res;
        // wider formats wrap ONE in the output field
        res_ext       = CW'(res);
        out_data_next = res_ext[OUT_W-1:0];
    end

endmodule

`default_nettype wire

FILE: verif/cbm_blend_checker.sv
`timescale 1ns / 100ps
// Scoreboard for coverage_blend_modes_unit: tracks the blend mode register, predicts
// the blended coverage of every input beat and compares it with the output beats.
// Depends on cbm_pkg and the channel interfaces in cbm_channels.sv.

module cbm_blend_checker #(
    parameter int FRAC_BITS = cbm_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cbm_pkg::MODE_W-1:0] cfg_data,
    cbm_in_if                          cov_in,
    cbm_out_if                         cov_out,
    output int                         mismatches,
    output int                         outstanding
);
    import cbm_pkg::*;

    localparam longint COV_ONE  = longint'(1) << FRAC_BITS;
    localparam longint COV_HALF = longint'(1) << (FRAC_BITS - 1);

    typedef struct {
        logic [MODE_W-1:0]      mode;
        logic signed [IN_W-1:0] base_cov;
        logic signed [IN_W-1:0] second_cov;
        logic [OUT_W-1:0]       blended;
    } blend_expect_t;

    blend_expect_t     blend_q[$];
    logic [MODE_W-1:0] mode_shadow;
    int                err_cnt = 0;

    assign mismatches = err_cnt;

    function automatic longint clamp_cov(input logic signed [IN_W-1:0] raw);
        longint v;
        v = raw;
        if (v < 0)
            return 0;
        return (v > COV_ONE) ? COV_ONE : v;
    endfunction

    function automatic logic [OUT_W-1:0] predict_blend(input logic [MODE_W-1:0] mode,
                                                       input logic signed [IN_W-1:0] base_raw,
                                                       input logic signed [IN_W-1:0] second_raw);
        longint a;
        longint b;
        longint q;
        longint r;
        a = clamp_cov(base_raw);
        b = clamp_cov(second_raw);
        if (a == 0)
            r = 0;
        else
        begin
            case (mode)
                MODE_MULTIPLY:
                    r = (a * b) >>> FRAC_BITS;
                MODE_OVERLAY:
                begin
                    if (a < COV_HALF)
                        r = (2 * a * b) >>> FRAC_BITS;
                    else
                    begin
                        q = (2 * (COV_ONE - a) * (COV_ONE - b)) >>> FRAC_BITS;
                        r = (q >= COV_ONE) ? 0 : COV_ONE - q;
                    end
                end
                MODE_BURN:
                begin
                    if (a >= COV_ONE)
                        r = COV_ONE;
                    else if (b == 0)
                        r = 0;
                    else
                    begin
                        q = ((COV_ONE - a) <<< FRAC_BITS) / b;
                        if (q > COV_ONE)
                            q = COV_ONE;
                        r = COV_ONE - q;
                    end
                end
                MODE_HARDMIX:
                    r = (a + b >= COV_ONE) ? COV_ONE : 0;
                MODE_LINBURN:
                    r = (a + b > COV_ONE) ? a + b - COV_ONE : 0;
                MODE_DODGE:
                begin
                    if (b >= COV_ONE)
                        r = COV_ONE;
                    else
                    begin
                        q = (a <<< FRAC_BITS) / (COV_ONE - b);
                        r = (q > COV_ONE) ? COV_ONE : q;
                    end
                end
                MODE_DARKEN:
                    r = (a < b) ? a : b;
                MODE_SUBTRACT, MODE_HEIGHT:
                    r = (a > b) ? a - b : 0;
                default:
                    r = a;
            endcase
        end
        if (r > COV_ONE)
            r = COV_ONE;
        return r[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        blend_expect_t e;
        if (!rst_n)
        begin
            mode_shadow <= MODE_MULTIPLY;
            blend_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                mode_shadow <= cfg_data;
            // retire the output beat first so a stray beat never eats a fresh prediction
            if (cov_out.valid && cov_out.ready)
            begin
                if (blend_q.size() == 0)
                    report_mismatch($sformatf("output beat %0d with nothing expected",
                                              cov_out.blended_coverage));
                else
                begin
                    e = blend_q.pop_front();
                    if (cov_out.blended_coverage !== e.blended)
                        report_mismatch($sformatf(
                            "mode %0d base %0d second %0d: got %0d, want %0d",
                            e.mode, e.base_cov, e.second_cov,
                            cov_out.blended_coverage, e.blended));
                end
            end
            if (cov_in.valid && cov_in.ready)
            begin
                e.mode       = mode_shadow;
                e.base_cov   = cov_in.base_coverage;
                e.second_cov = cov_in.second_coverage;
                e.blended    = predict_blend(mode_shadow, cov_in.base_coverage,
                                             cov_in.second_coverage);
                blend_q.push_back(e);
            end
            outstanding <= blend_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Top of the coverage blend bench: clock, reset, blend mode writes, corner and random
// beats under several idle and stall patterns, and the verdict.
// Depends on cbm_pkg, cbm_channels.sv, coverage_blend_modes_unit and cbm_blend_checker.

module tb;
    import cbm_pkg::*;

    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    localparam int COV_ONE     = 1 << FRAC_BITS;
    localparam int COV_HALF    = COV_ONE / 2;
    localparam int IN_MAX      = (1 << (IN_W - 1)) - 1;
    localparam int IN_MIN      = -(1 << (IN_W - 1));
    localparam int LATENCY     = FRAC_BITS + 5;
    localparam int HOLD_CYCLES = 4 * LATENCY;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 42;
    localparam int LIMIT_NS    = 2_000_000;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd10;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_style_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        int                base_cov;
        int                second_cov;
    } corner_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [MODE_W-1:0] cfg_data;

    int chk_fail;
    int chk_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_served    = 0;
    int beats_sent     = 0;
    int mode_writes    = 0;

    cbm_in_if  cov_in();
    cbm_out_if cov_out();

    coverage_blend_modes_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cov_in   (cov_in),
        .cov_out  (cov_out)
    );

    cbm_blend_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cov_in      (cov_in),
        .cov_out     (cov_out),
        .mismatches  (chk_fail),
        .outstanding (chk_pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // output side: random stalls, plus one long hold-off per request
    initial
    begin
        cov_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_served)
            begin
                hold_served = hold_req;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    cov_out.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            cov_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int pick_coverage();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom_range(COV_ONE, 0);
        if (sel < 55)
        begin
            case ($urandom_range(7))
                0:       return 0;
                1:       return 1;
                2:       return COV_HALF - 1;
                3:       return COV_HALF;
                4:       return COV_HALF + 1;
                5:       return COV_ONE - 1;
                6:       return COV_ONE;
                default: return COV_ONE + 1;
            endcase
        end
        if (sel < 70)
        begin
            v = $urandom_range(-IN_MIN, 1);
            return -v;
        end
        if (sel < 85)
            return $urandom_range(IN_MAX, COV_ONE + 1);
        v = $urandom();
        return v;
    endfunction

    task automatic send_beat(input int base_val, input int second_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cov_in.valid <= 1'b0;
            @(posedge clk);
        end
        cov_in.valid           <= 1'b1;
        cov_in.base_coverage   <= base_val[IN_W-1:0];
        cov_in.second_coverage <= second_val[IN_W-1:0];
        do
            @(posedge clk);
        while (!cov_in.ready);
        beats_sent++;
    endtask

    task automatic drain();
        cov_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
    endtask

    // write the mode only with the pipeline empty
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        drain();
        cfg_data <= mode;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_writes++;
    endtask

    task automatic set_idling(input idle_style_t style);
        send_idle_pct = (style == IDLE_SEND) ? 48 : (style == IDLE_BOTH) ? 23 : 0;
        recv_stall_pct <= (style == IDLE_RECV) ? 48 : (style == IDLE_BOTH) ? 23 : 0;
    endtask

    initial
    begin
        corner_t           corners[$];
        logic [MODE_W-1:0] plan[RAND_PHASES];
        logic [MODE_W-1:0] mode;
        int                cur_mode;
        int                base_val;
        int                second_val;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_data               = MODE_MULTIPLY;
        cov_in.valid           = 1'b0;
        cov_in.base_coverage   = '0;
        cov_in.second_coverage = '0;

        corners.push_back('{MODE_MULTIPLY, IN_MAX, IN_MAX});
        corners.push_back('{MODE_MULTIPLY, IN_MIN, IN_MIN});
        corners.push_back('{MODE_MULTIPLY, COV_HALF, COV_HALF});
        corners.push_back('{MODE_OVERLAY, COV_HALF - 1, COV_ONE});
        corners.push_back('{MODE_OVERLAY, COV_HALF, 0});
        // burn: saturated primary, pole at zero secondary, deep burn
        corners.push_back('{MODE_BURN, COV_ONE, 0});
        corners.push_back('{MODE_BURN, 1000, 0});
        corners.push_back('{MODE_BURN, 1, COV_ONE});
        corners.push_back('{MODE_BURN, COV_HALF, 1});
        corners.push_back('{MODE_HARDMIX, COV_HALF, COV_HALF});
        corners.push_back('{MODE_HARDMIX, COV_HALF, COV_HALF - 1});
        corners.push_back('{MODE_LINBURN, COV_ONE, COV_ONE});
        corners.push_back('{MODE_LINBURN, COV_HALF, COV_HALF + 1});
        // dodge: pole at full secondary, quotient saturation, plain copy
        corners.push_back('{MODE_DODGE, 1, COV_ONE});
        corners.push_back('{MODE_DODGE, COV_ONE, COV_ONE - 1});
        corners.push_back('{MODE_DODGE, COV_HALF, 0});
        corners.push_back('{MODE_DARKEN, 0, COV_ONE});
        corners.push_back('{MODE_SUBTRACT, -5, 100});
        corners.push_back('{MODE_SUBTRACT, COV_ONE, 1});
        corners.push_back('{MODE_HEIGHT, COV_ONE, COV_HALF});
        corners.push_back('{MODE_LINHEIGHT, COV_ONE + 7, 0});
        corners.push_back('{MODE_UNUSED_LO, 12345, 999});
        corners.push_back('{MODE_UNUSED_HI, IN_MAX, IN_MIN});

        plan = '{MODE_MULTIPLY, MODE_OVERLAY, MODE_BURN, MODE_HARDMIX, MODE_LINBURN,
                 MODE_DODGE, MODE_DARKEN, MODE_SUBTRACT, MODE_HEIGHT, MODE_LINHEIGHT,
                 MODE_UNUSED_HI, MODE_UNUSED_LO};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_mode = -1;
        foreach (corners[i])
        begin
            if (int'(corners[i].mode) != cur_mode)
            begin
                write_mode(corners[i].mode);
                cur_mode = int'(corners[i].mode);
            end
            send_beat(corners[i].base_cov, corners[i].second_cov);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            mode = plan[ph];
            if (ph == RAND_PHASES - 1)
                mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
            write_mode(mode);
            set_idling(idle_style_t'(ph % 4));
            // hold the output long enough to fill the pipe and back up the input
            if (ph == 4)
                hold_req <= hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                base_val   = pick_coverage();
                second_val = pick_coverage();
                if ($urandom_range(9) == 0)
                    second_val = COV_ONE - base_val + int'($urandom_range(2)) - 1;
                send_beat(base_val, second_val);
            end
        end

        drain();
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d beats over %0d mode writes: corner vectors, every defined mode",
                 beats_sent, mode_writes);
        $display("and unused codes, sender gaps, output stalls and one long output hold-off");
        if (chk_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
src/cbm_pkg.sv
src/cbm_channels.sv
src/cbm_div_pipe.sv
src/coverage_blend_modes_unit.sv
verif/cbm_blend_checker.sv
verif/tb.sv
